FILE: sv/oale_pkg.sv
`timescale 1ns / 1ps
// package for the ordered array list engine
// opcodes, status codes and sequencer state type; no dependencies

package oale_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_SORT   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_SORT_RDX,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_DONE
    } t_state;

endpackage

FILE: sv/ordered_array_list_engine.sv
`timescale 1ns / 1ps
// ordered array list engine: fixed-capacity list of signed words in one memory
// depends on oale_pkg
//
// usage: drive i_opcode, i_item_value and i_position and raise start while
// busy is low; the command is taken at that edge and busy is high from the
// next cycle. exactly one result per command appears on o_status,
// o_result_value and o_list_length for one cycle with o_done high. busy stays
// high through that cycle and drops in the cycle after it, so the next start
// transfer can happen in the cycle after the result.
// the receiver cannot stall, so it must take the result when o_done is high.
// the single-port memory does one read or write per cycle, and the commands
// walk the list through it: get reads one entry; find / delete by value
// scan entries in order; insert / delete scan or move entries, at most about
// CAPACITY of them; sort is an insertion sort that compares and moves entries.
// reset clears the length to zero; the memory is not cleared, only entries
// below the length are ever read.
// CAPACITY sets the memory depth and may be 2 to 64 with a 7-bit length.

module ordered_array_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_item_value,
    input  logic signed [7:0]  i_position,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [6:0]         o_list_length
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    oale_pkg::t_state r_state, n_state;
    logic [6:0]  r_len, n_len;
    logic [2:0]  r_op, n_op;
    logic [31:0] r_item, n_item;
    logic [6:0]  r_i, n_i;      // main index
    logic [6:0]  r_j, n_j;      // sort inner index / target slot
    logic [31:0] r_x, n_x;      // held word
    logic [2:0]  r_st, n_st;
    logic [31:0] r_val, n_val;
    logic        r_pdel, n_pdel; // removed word already captured

    logic [31:0] mem [CAPACITY];
    logic [31:0] r_rd;
    logic        mem_we;
    logic [6:0]  mem_addr;
    logic [31:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr[AW-1:0]] <= mem_wd;
        end
        r_rd <= mem[mem_addr[AW-1:0]];
    end

    logic signed [8:0] pos9;
    logic signed [8:0] len9;
    logic              less_x;
    assign pos9   = {i_position[7], i_position};
    assign len9   = {2'b00, r_len};
    assign less_x = $signed(r_x) < $signed(r_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oale_pkg::S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
        r_op <= n_op; r_item <= n_item; r_i <= n_i; r_j <= n_j;
        r_x <= n_x; r_st <= n_st; r_val <= n_val; r_pdel <= n_pdel;
    end

    always_comb begin
        n_state = r_state; n_len = r_len; n_op = r_op; n_item = r_item;
        n_i = r_i; n_j = r_j; n_x = r_x; n_st = r_st; n_val = r_val;
        n_pdel = r_pdel;
        mem_we = 1'b0; mem_addr = r_i; mem_wd = r_x;
        busy = (r_state != oale_pkg::S_IDLE);
        o_done = 1'b0;
        case (r_state)
            oale_pkg::S_IDLE: begin
                if (start) begin
                    n_op = i_opcode; n_item = i_item_value; n_x = i_item_value;
                    n_val = '0; n_st = oale_pkg::ST_OK; n_i = '0;
                    n_state = oale_pkg::S_DONE;
                    case (i_opcode)
                        oale_pkg::OP_INSERT: begin
                            if (pos9 < -9'sd1 || pos9 > len9 + 9'sd1)
                                n_st = oale_pkg::ST_BADPOS;
                            else if (r_len >= 7'(CAPACITY))
                                n_st = oale_pkg::ST_FULL;
                            else if (pos9 == 9'sd0 && r_len != '0) begin
                                n_pdel = 1'b0;
                                n_state = oale_pkg::S_SCAN_RD;
                            end else begin
                                // end of list or given position, also ascending insert into an empty list
                                n_j = (pos9 <= 9'sd0) ? r_len : 7'(pos9 - 9'sd1);
                                n_i = r_len;
                                n_state = oale_pkg::S_SHUP_RD;
                            end
                        end
                        oale_pkg::OP_DELETE: begin
                            if (r_len == '0) n_st = oale_pkg::ST_EMPTY;
                            else if (pos9 < -9'sd1 || pos9 > len9)
                                n_st = oale_pkg::ST_BADPOS;
                            else if (pos9 == 9'sd0) begin
                                n_pdel = 1'b0;
                                n_state = oale_pkg::S_SCAN_RD;
                            end else begin
                                n_i = (pos9 == -9'sd1) ? r_len - 7'd1
                                                       : 7'(pos9 - 9'sd1);
                                n_state = oale_pkg::S_SHDN_RD;
                                n_pdel = 1'b0;
                            end
                        end
                        oale_pkg::OP_GET: begin
                            if (pos9 >= 9'sd1 && pos9 <= len9) begin
                                n_i = 7'(pos9 - 9'sd1);
                                n_j = 7'(pos9 - 9'sd1);
                                n_state = oale_pkg::S_SCAN_RD;
                            end else
                                n_st = oale_pkg::ST_BADPOS;
                        end
                        oale_pkg::OP_FIND: begin
                            n_st = oale_pkg::ST_NOTFOUND;
                            if (r_len != '0) n_state = oale_pkg::S_SCAN_RD;
                        end
                        oale_pkg::OP_SORT: begin
                            n_i = 7'd1;
                            if (r_len > 7'd1) n_state = oale_pkg::S_SORT_RDX;
                        end
                        default: n_st = oale_pkg::ST_BADPOS;
                    endcase
                end
            end
            // read slot r_i, memory data arrives next cycle
            oale_pkg::S_SCAN_RD: begin
                mem_addr = r_i;
                n_state = oale_pkg::S_SCAN_CMP;
            end
            oale_pkg::S_SCAN_CMP: begin
                case (r_op)
                    oale_pkg::OP_GET: begin
                        n_val = r_rd;
                        n_state = oale_pkg::S_DONE;
                    end
                    oale_pkg::OP_FIND: begin
                        if (r_rd == r_item) begin
                            n_val = r_rd; n_st = oale_pkg::ST_OK;
                            n_state = oale_pkg::S_DONE;
                        end else if (r_i + 7'd1 >= r_len)
                            n_state = oale_pkg::S_DONE;
                        else begin
                            n_i = r_i + 7'd1;
                            n_state = oale_pkg::S_SCAN_RD;
                        end
                    end
                    oale_pkg::OP_DELETE: begin
                        if (r_rd == r_item) begin
                            n_state = oale_pkg::S_SHDN_RD;
                        end else if (r_i + 7'd1 >= r_len) begin
                            n_st = oale_pkg::ST_NOTFOUND;
                            n_state = oale_pkg::S_DONE;
                        end else begin
                            n_i = r_i + 7'd1;
                            n_state = oale_pkg::S_SCAN_RD;
                        end
                    end
                    default: begin
                        // ascending insert: first entry strictly greater
                        if (less_x) begin
                            n_j = r_i; n_i = r_len;
                            n_state = oale_pkg::S_SHUP_RD;
                        end else if (r_i + 7'd1 >= r_len) begin
                            n_j = r_len; n_i = r_len;
                            n_state = oale_pkg::S_SHUP_RD;
                        end else begin
                            n_i = r_i + 7'd1;
                            n_state = oale_pkg::S_SCAN_RD;
                        end
                    end
                endcase
            end
            // shift up: entries[i] = entries[i-1] while i > j, then entries[j] = x
            oale_pkg::S_SHUP_RD: begin
                if (r_i > r_j) begin
                    mem_addr = r_i - 7'd1;
                    n_state = oale_pkg::S_SHUP_WR;
                end else begin
                    mem_we = 1'b1; mem_addr = r_j; mem_wd = r_x;
                    n_len = r_len + 7'd1;
                    n_state = oale_pkg::S_DONE;
                end
            end
            oale_pkg::S_SHUP_WR: begin
                mem_we = 1'b1; mem_addr = r_i; mem_wd = r_rd;
                n_i = r_i - 7'd1;
                n_state = oale_pkg::S_SHUP_RD;
            end
            // shift down: read slot i first to capture removed word
            oale_pkg::S_SHDN_RD: begin
                mem_addr = r_i;
                n_state = oale_pkg::S_SHDN_WR;
            end
            oale_pkg::S_SHDN_WR: begin
                if (!r_pdel) begin
                    // first read: removed word
                    n_val = r_rd; n_pdel = 1'b1;
                end else begin
                    mem_we = 1'b1; mem_addr = r_i - 7'd1; mem_wd = r_rd;
                end
                if (r_i + 7'd1 >= r_len) begin
                    n_len = r_len - 7'd1;
                    n_state = oale_pkg::S_DONE;
                end else begin
                    n_i = r_i + 7'd1;
                    n_state = oale_pkg::S_SHDN_RD;
                end
            end
            // insertion sort: x = entries[i], walk j down
            oale_pkg::S_SORT_RDX: begin
                if (r_i >= r_len) n_state = oale_pkg::S_DONE;
                else begin
                    mem_addr = r_i;
                    n_j = r_i;
                    n_state = oale_pkg::S_SORT_RDJ;
                end
            end
            oale_pkg::S_SORT_RDJ: begin
                if (r_j == r_i) n_x = r_rd;
                if (r_j == '0) begin
                    mem_we = 1'b1; mem_addr = r_j;
                    mem_wd = (r_j == r_i) ? r_rd : r_x;
                    n_i = r_i + 7'd1;
                    n_state = oale_pkg::S_SORT_RDX;
                end else begin
                    mem_addr = r_j - 7'd1;
                    n_state = oale_pkg::S_SORT_CMP;
                end
            end
            oale_pkg::S_SORT_CMP: begin
                mem_we = 1'b1; mem_addr = r_j;
                if (less_x) begin
                    mem_wd = r_rd;
                    n_j = r_j - 7'd1;
                    n_state = oale_pkg::S_SORT_RDJ;
                end else begin
                    mem_wd = r_x;
                    n_i = r_i + 7'd1;
                    n_state = oale_pkg::S_SORT_RDX;
                end
            end
            oale_pkg::S_DONE: begin
                // result cycle, still busy so no transfer lands here
                o_done = 1'b1;
                n_state = oale_pkg::S_IDLE;
            end
            default: n_state = oale_pkg::S_IDLE;
        endcase
    end

    assign o_status       = r_st;
    assign o_result_value = (r_st == oale_pkg::ST_OK) ? r_val : '0;
    assign o_list_length  = r_len;

endmodule

FILE: bench/tb_ordered_array_list_engine.sv
`timescale 1ns / 1ps
// self-checking bench for the ordered array list engine: directed table then random commands
// depends on oale_pkg and ordered_array_list_engine; keeps its own list model

module tb_ordered_array_list_engine;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 20000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_opcode;
    logic signed [31:0] i_item_value;
    logic signed [7:0]  i_position;
    logic               o_done;
    logic [2:0]         o_status;
    logic signed [31:0] o_result_value;
    logic [6:0]         o_list_length;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic [6:0]         length;
    } t_outcome;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic signed [7:0]  pos;
        bit                 typed;
        t_outcome           want;
    } t_row;

    // model of the list contents
    logic signed [31:0] list_words[CAP];
    int                 list_len;
    t_outcome           pending_outcomes[$];
    int                 errors;
    int                 cycles;
    int                 send_idle_pct;

    ordered_array_list_engine #(.CAPACITY(CAP)) uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_outcome apply_command(logic [2:0] op, logic signed [31:0] v,
                                               logic signed [7:0] pos_in);
        t_outcome r;
        int p;
        int slot;
        logic signed [31:0] x;
        int j;
        p = pos_in;
        r.status = oale_pkg::ST_BADPOS;
        r.value = '0;
        case (op)
            oale_pkg::OP_INSERT: begin
                if (p < -1 || p > list_len + 1) r.status = oale_pkg::ST_BADPOS;
                else if (list_len >= CAP) r.status = oale_pkg::ST_FULL;
                else begin
                    if (p == 0) begin
                        slot = list_len;
                        for (int k = list_len - 1; k >= 0; k--)
                            if (v < list_words[k]) slot = k;
                    end else if (p == -1) slot = list_len;
                    else slot = p - 1;
                    for (int k = list_len; k > slot; k--) list_words[k] = list_words[k-1];
                    list_words[slot] = v;
                    list_len++;
                    r.status = oale_pkg::ST_OK;
                end
            end
            oale_pkg::OP_DELETE: begin
                if (list_len == 0) r.status = oale_pkg::ST_EMPTY;
                else if (p < -1 || p > list_len) r.status = oale_pkg::ST_BADPOS;
                else begin
                    slot = -1;
                    if (p == 0) begin
                        for (int k = list_len - 1; k >= 0; k--)
                            if (list_words[k] == v) slot = k;
                    end else if (p == -1) slot = list_len - 1;
                    else slot = p - 1;
                    if (slot < 0) r.status = oale_pkg::ST_NOTFOUND;
                    else begin
                        r.value = list_words[slot];
                        for (int k = slot + 1; k < list_len; k++) list_words[k-1] = list_words[k];
                        list_len--;
                        r.status = oale_pkg::ST_OK;
                    end
                end
            end
            oale_pkg::OP_GET: begin
                if (p >= 1 && p <= list_len) begin
                    r.value = list_words[p-1];
                    r.status = oale_pkg::ST_OK;
                end
            end
            oale_pkg::OP_FIND: begin
                r.status = oale_pkg::ST_NOTFOUND;
                for (int k = 0; k < list_len; k++)
                    if (r.status != oale_pkg::ST_OK && list_words[k] == v) begin
                        r.value = v;
                        r.status = oale_pkg::ST_OK;
                    end
            end
            oale_pkg::OP_SORT: begin
                // stable insertion sort
                for (int k = 1; k < list_len; k++) begin
                    x = list_words[k];
                    j = k;
                    while (j > 0 && x < list_words[j-1]) begin
                        list_words[j] = list_words[j-1];
                        j--;
                    end
                    list_words[j] = x;
                end
                r.status = oale_pkg::ST_OK;
            end
            default: r.status = oale_pkg::ST_BADPOS;
        endcase
        r.length = list_len[6:0];
        return r;
    endfunction

    task automatic issue_command(logic [2:0] op, logic signed [31:0] v, logic signed [7:0] pos,
                                 bit typed, t_outcome want);
        t_outcome pred;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_opcode <= op;
        i_item_value <= v;
        i_position <= pos;
        start <= 1'b1;
        // busy is steady at the falling edge and holds up to the next rising edge
        while (busy) @(negedge i_clk);
        pred = apply_command(op, v, pos);
        if (typed && pred !== want)
            $display("%0t table row disagrees with model: table %h model %h",
                     $time, want, pred);
        pending_outcomes.push_back(typed ? want : pred);
        @(posedge i_clk);
        @(negedge i_clk);
        start <= 1'b0;
        // wait for this transfer's result so busy is settled
        while (pending_outcomes.size() != 0) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t unexpected result: status %0d value %0d length %0d",
                         $time, o_status, o_result_value, o_list_length);
                errors++;
            end else begin
                exp_r = pending_outcomes.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t status: expected %0d actual %0d", $time, exp_r.status, o_status);
                    errors++;
                end
                if (o_result_value !== exp_r.value) begin
                    $display("%0t value: expected %0d actual %0d",
                             $time, exp_r.value, o_result_value);
                    errors++;
                end
                if (o_list_length !== exp_r.length) begin
                    $display("%0t length: expected %0d actual %0d",
                             $time, exp_r.length, o_list_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_outcome oc(logic [2:0] s, logic signed [31:0] v, int n);
        t_outcome r;
        r.status = s;
        r.value = v;
        r.length = n[6:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(3))
            0: return $signed($urandom_range(7)) - 4;
            1: return 32'sh7fffffff - $urandom_range(3);
            2: return 32'sh80000000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    t_row dir_rows[$];
    t_outcome none;

    initial begin
        logic [2:0] op;
        logic signed [31:0] v;
        logic signed [7:0] pos;
        int sel;
        errors = 0;
        cycles = 0;
        send_idle_pct = 33;
        none = '0;
        list_len = 0;
        start = 1'b0;
        i_opcode = oale_pkg::OP_GET;
        i_item_value = '0;
        i_position = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list, extremes, error codes
        dir_rows = '{
            '{oale_pkg::OP_DELETE, 32'sd5, 8'sd0, 1, oc(oale_pkg::ST_EMPTY, 0, 0)},
            '{oale_pkg::OP_GET, 32'sd0, 8'sd1, 1, oc(oale_pkg::ST_BADPOS, 0, 0)},
            '{oale_pkg::OP_FIND, 32'sd0, 8'sd0, 1, oc(oale_pkg::ST_NOTFOUND, 0, 0)},
            '{oale_pkg::OP_SORT, 32'sd0, 8'sd0, 1, oc(oale_pkg::ST_OK, 0, 0)},
            '{oale_pkg::OP_INSERT, 32'sd1, 8'sd2, 1, oc(oale_pkg::ST_BADPOS, 0, 0)},
            '{oale_pkg::OP_INSERT, 32'sd1, -8'sd2, 1, oc(oale_pkg::ST_BADPOS, 0, 0)},
            '{3'd5, 32'sd0, 8'sd0, 1, oc(oale_pkg::ST_BADPOS, 0, 0)},
            '{3'd7, -32'sd1, -8'sd1, 1, oc(oale_pkg::ST_BADPOS, 0, 0)},
            '{oale_pkg::OP_INSERT, 32'sh7fffffff, -8'sd1, 1, oc(oale_pkg::ST_OK, 0, 1)},
            '{oale_pkg::OP_INSERT, 32'sh80000000, 8'sd1, 1, oc(oale_pkg::ST_OK, 0, 2)},
            '{oale_pkg::OP_GET, 32'sd0, 8'sd2, 1, oc(oale_pkg::ST_OK, 32'sh7fffffff, 2)},
            '{oale_pkg::OP_GET, 32'sd0, 8'sd0, 1, oc(oale_pkg::ST_BADPOS, 0, 2)},
            '{oale_pkg::OP_GET, 32'sd0, -8'sd1, 1, oc(oale_pkg::ST_BADPOS, 0, 2)},
            '{oale_pkg::OP_INSERT, 32'sd0, 8'sd0, 0, none},
            '{oale_pkg::OP_INSERT, 32'sd0, 8'sd0, 0, none},
            '{oale_pkg::OP_INSERT, -32'sd1, 8'sd3, 0, none},
            '{oale_pkg::OP_FIND, 32'sh80000000, 8'sd0, 1,
              oc(oale_pkg::ST_OK, 32'sh80000000, 5)},
            '{oale_pkg::OP_SORT, 32'sd0, 8'sd0, 0, none},
            '{oale_pkg::OP_DELETE, 32'sd9, 8'sd0, 1, oc(oale_pkg::ST_NOTFOUND, 0, 5)},
            '{oale_pkg::OP_DELETE, 32'sd0, 8'sd6, 1, oc(oale_pkg::ST_BADPOS, 0, 5)},
            '{oale_pkg::OP_DELETE, 32'sd0, -8'sd1, 1,
              oc(oale_pkg::ST_OK, 32'sh7fffffff, 4)},
            '{oale_pkg::OP_DELETE, 32'sd0, 8'sd0, 0, none},
            '{oale_pkg::OP_DELETE, 32'sd0, 8'sd1, 1,
              oc(oale_pkg::ST_OK, 32'sh80000000, 2)},
            '{oale_pkg::OP_INSERT, 32'sd0, -8'sd128, 1, oc(oale_pkg::ST_BADPOS, 0, 2)},
            '{oale_pkg::OP_GET, 32'sd0, 8'sd127, 1, oc(oale_pkg::ST_BADPOS, 0, 2)}
        };
        foreach (dir_rows[k])
            issue_command(dir_rows[k].op, dir_rows[k].value, dir_rows[k].pos,
                          dir_rows[k].typed, dir_rows[k].want);

        for (int n = 0; n < 900; n++) begin
            if (n == 300) send_idle_pct = 83;
            if (n == 600) send_idle_pct = 0;
            sel = $urandom_range(99);
            // phases lean toward growth, then shrinkage, so both full and empty are seen
            if (sel < ((n / 150) % 2 == 0 ? 50 : 20)) op = oale_pkg::OP_INSERT;
            else if (sel < 65) op = oale_pkg::OP_DELETE;
            else if (sel < 78) op = oale_pkg::OP_GET;
            else if (sel < 90) op = oale_pkg::OP_FIND;
            else if (sel < 95) op = oale_pkg::OP_SORT;
            else op = 3'($urandom_range(7));
            v = ($urandom_range(3) == 0 && list_len > 0) ?
                list_words[$urandom_range(list_len - 1)] : rand_word();
            case ($urandom_range(9))
                0: pos = 8'sd0;
                1: pos = -8'sd1;
                2: pos = 8'($urandom);
                3: pos = 8'(list_len + 1 + int'($urandom_range(1)));
                default: pos = 8'($urandom_range(list_len + 1));
            endcase
            issue_command(op, v, pos, 0, none);
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
